/* rtl/spc_pkg.sv */
package spc_pkg;

   // Framing bytes
   localparam logic [7:0] HDR0_BYTE = 8'hFF;
   localparam logic [7:0] HDR1_BYTE = 8'h00;
   localparam logic [7:0] TERM_BYTE = 8'h0A;

   // Widths of the packet state and the register
   localparam int POS_W = 9;
   localparam int BYTE_W = 8;
   localparam int LEN_W = 9;

   // Reset value of the packet length limit
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd260;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_HEADER   = 3'd1,
      ST_ZERO_LEN     = 3'd2,
      ST_OVERRUN      = 3'd3,
      ST_CKSUM        = 3'd4,
      ST_LEN_MISMATCH = 3'd5
   } status_type;

   // Per-packet state carried from one byte to the next
   typedef struct packed {
      logic [POS_W-1:0]  byte_position;
      logic [BYTE_W-1:0] running_sum;
      logic [BYTE_W-1:0] previous_byte;
      logic [BYTE_W-1:0] declared_length;
      status_type        first_error;
   } pkt_state_type;

   // What one byte produces
   typedef struct packed {
      logic              emit;
      status_type        status;
      logic [BYTE_W-1:0] payload_count;
   } step_result_type;

endpackage

/* rtl/spc_step.sv */
module spc_step (
   input  spc_pkg::pkt_state_type           cur_state,
   input  logic [spc_pkg::BYTE_W-1:0]       data_byte,
   input  logic [spc_pkg::LEN_W-1:0]        max_packet_len,
   output spc_pkg::pkt_state_type           next_state,
   output spc_pkg::step_result_type         result
);

   logic                          term_hit;
   logic [spc_pkg::POS_W:0]       pos_plus1;
   logic [spc_pkg::POS_W-1:0]     count_full;
   spc_pkg::status_type           ferr_upd;
   logic [spc_pkg::BYTE_W-1:0]    len_upd;
   logic [spc_pkg::BYTE_W-1:0]    sum_upd;
   spc_pkg::status_type           term_status;

   // A terminator only counts once the header has been passed.
   assign term_hit = (cur_state.byte_position >= spc_pkg::POS_W'(3)) &&
                     (data_byte == spc_pkg::TERM_BYTE);
   assign pos_plus1 = {1'b0, cur_state.byte_position} + (spc_pkg::POS_W+1)'(1);
   assign count_full = cur_state.byte_position - spc_pkg::POS_W'(4);

   // Status on a terminator, in priority order.
   always_comb begin
      if (cur_state.first_error != spc_pkg::ST_OK) begin
         term_status = cur_state.first_error;
      end else if (cur_state.byte_position == spc_pkg::POS_W'(3)) begin
         term_status = spc_pkg::ST_LEN_MISMATCH;
      end else if (cur_state.running_sum != cur_state.previous_byte) begin
         term_status = spc_pkg::ST_CKSUM;
      end else if (count_full != {1'b0, cur_state.declared_length}) begin
         term_status = spc_pkg::ST_LEN_MISMATCH;
      end else begin
         term_status = spc_pkg::ST_OK;
      end
   end

   // Header checks, length capture and checksum accumulation for a plain byte.
   always_comb begin
      ferr_upd = cur_state.first_error;
      len_upd  = cur_state.declared_length;
      sum_upd  = cur_state.running_sum;
      case (cur_state.byte_position)
         spc_pkg::POS_W'(0): begin
            if (data_byte != spc_pkg::HDR0_BYTE && cur_state.first_error == spc_pkg::ST_OK) begin
               ferr_upd = spc_pkg::ST_BAD_HEADER;
            end
         end
         spc_pkg::POS_W'(1): begin
            if (data_byte != spc_pkg::HDR1_BYTE && cur_state.first_error == spc_pkg::ST_OK) begin
               ferr_upd = spc_pkg::ST_BAD_HEADER;
            end
         end
         spc_pkg::POS_W'(2): begin
            len_upd = data_byte;
            if (data_byte == '0 && cur_state.first_error == spc_pkg::ST_OK) begin
               ferr_upd = spc_pkg::ST_ZERO_LEN;
            end
         end
         spc_pkg::POS_W'(3): begin
            sum_upd = cur_state.running_sum;
         end
         default: begin
            sum_upd = cur_state.running_sum + cur_state.previous_byte;
         end
      endcase
   end

   // Pick between terminator, overrun and an ordinary byte.
   always_comb begin
      next_state = '0;
      result.emit = 1'b0;
      result.status = spc_pkg::ST_OK;
      result.payload_count = '0;
      if (term_hit) begin
         result.emit = 1'b1;
         result.status = term_status;
         if (cur_state.byte_position >= spc_pkg::POS_W'(4)) begin
            result.payload_count = count_full[spc_pkg::POS_W-1] ? '1 :
                                   count_full[spc_pkg::BYTE_W-1:0];
         end
      end else if (pos_plus1 >= {1'b0, max_packet_len}) begin
         result.emit = 1'b1;
         result.status = (ferr_upd != spc_pkg::ST_OK) ? ferr_upd : spc_pkg::ST_OVERRUN;
      end else begin
         next_state.byte_position   = pos_plus1[spc_pkg::POS_W-1:0];
         next_state.running_sum     = sum_upd;
         next_state.previous_byte   = data_byte;
         next_state.declared_length = len_upd;
         next_state.first_error     = ferr_upd;
      end
   end

endmodule

/* rtl/serial_packet_checker.sv */
// The result for the item that ends a packet is formed from the input register and loaded
// into the result register. Throughput: one byte per cycle while no held result stalls the
// input; the packet state updates in a single pass between the input and result registers.
// Reset (synchronous, active high) clears the packet state and both valid flags,
// and sets the packet length limit to 260 bytes.
module serial_packet_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [spc_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [spc_pkg::BYTE_W-1:0]    rsp_payload_count,
   input  logic                          csr_wr_en,
   input  logic [spc_pkg::LEN_W-1:0]     csr_wr_data
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic [spc_pkg::BYTE_W-1:0]    in_byte_ff;
   logic [spc_pkg::LEN_W-1:0]     max_len_ff;
   spc_pkg::pkt_state_type        state_ff;
   spc_pkg::pkt_state_type        state_in;
   spc_pkg::step_result_type      step_res;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   spc_pkg::status_type           rsp_status_ff;
   logic [spc_pkg::BYTE_W-1:0]    rsp_count_ff;
   logic                          out_free;
   logic                          advance;
   logic                          out_load;

   spc_step u_step (
      .cur_state      (state_ff),
      .data_byte      (in_byte_ff),
      .max_packet_len (max_len_ff),
      .next_state     (state_in),
      .result         (step_res)
   );

   // A byte moves on unless it ends a packet while the result register is held.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!step_res.emit || out_free);
   assign out_load  = advance && step_res.emit;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // Control registers and length limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         max_len_ff   <= spc_pkg::MAX_LEN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (out_load) begin
         rsp_status_ff <= step_res.status;
         rsp_count_ff  <= step_res.payload_count;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_payload_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // Every emitted packet leaves the state at the start of a new packet.
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (state_ff.byte_position == '0 && state_ff.first_error == spc_pkg::ST_OK))
      else $error("packet state not cleared after a result");

   // Overrun never carries a payload count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status_ff == spc_pkg::ST_OVERRUN) |-> rsp_payload_count == '0)
      else $error("overrun result with non-zero count");

   // A held byte stays in the input register until it can proceed.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held byte lost from input register");

   // Position never reaches the largest value the counter can hold.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_position != '1)
      else $error("byte position out of range");
`endif

endmodule

/* dv/serial_packet_checker_test.sv */
`timescale 1ns / 100ps

module serial_packet_checker_test;

   // Longest stretch with no item accepted on either channel before giving up.
   localparam int STUCK_LIMIT = 2000;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int HOLD_CYCLES = 300;
   // Cycles allowed after the last result for anything still in flight.
   localparam int SETTLE_CYCLES = 4;

   typedef enum {
      PK_GOOD, PK_LEN_OFF, PK_BAD_SUM, PK_BAD_HDR, PK_ZERO_LEN, PK_OVERRUN, PK_NOISE, PK_LONG
   } frame_kind_type;

   typedef struct packed {
      spc_pkg::status_type  status;
      logic [7:0]           count;
   } frame_verdict_type;

   typedef struct packed {
      logic [7:0]           data;
      logic                 typed;
      spc_pkg::status_type  status;
      logic [7:0]           count;
   } frame_step_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_data_byte;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [2:0]                rsp_status;
   logic [7:0]                rsp_payload_count;
   logic                      csr_wr_en;
   logic [spc_pkg::LEN_W-1:0] csr_wr_data;

   // Expectation typed into the opening table travels alongside its item.
   logic                      req_typed;
   spc_pkg::status_type       req_typed_status;
   logic [7:0]                req_typed_count;

   // Own copy of the packet state and the length limit.
   logic [spc_pkg::LEN_W-1:0] limit_len;
   logic [spc_pkg::POS_W-1:0] pkt_pos;
   logic [7:0]                pkt_sum;
   logic [7:0]                pkt_prev;
   logic [7:0]                pkt_decl;
   spc_pkg::status_type       pkt_err;

   frame_verdict_type  verdicts_due[$];
   int                 fail_count;
   int                 stuck_cycles;
   int                 burst_left;
   int                 bytes_offered;
   bit                 hold_wanted;

   // Opening bytes: a good packet with extreme payload values, a header full of
   // early terminators, zero length, a terminator straight after the length
   // byte, and a checksum error.
   frame_step_type opening_bytes [0:24] = '{
      '{8'hFF, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h00, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h02, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h80, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h7F, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'hFF, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h0A, 1'b1, spc_pkg::ST_OK, 8'd2},
      '{8'h0A, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h0A, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h0A, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h0A, 1'b1, spc_pkg::ST_BAD_HEADER, 8'd0},
      '{8'hFF, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h00, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h00, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h0A, 1'b1, spc_pkg::ST_ZERO_LEN, 8'd0},
      '{8'hFF, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h00, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h01, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h0A, 1'b1, spc_pkg::ST_LEN_MISMATCH, 8'd0},
      '{8'hFF, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h00, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h01, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h55, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h00, 1'b0, spc_pkg::ST_OK, 8'd0},
      '{8'h0A, 1'b1, spc_pkg::ST_CKSUM, 8'd1}
   };

   serial_packet_checker u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_payload_count (rsp_payload_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Returns the packet state to its empty form.
   task automatic clear_packet();
      pkt_pos  = '0;
      pkt_sum  = '0;
      pkt_prev = '0;
      pkt_decl = '0;
      pkt_err  = spc_pkg::ST_OK;
   endtask

   // Advances the packet state by one byte and gives the status it ends with, if any.
   task automatic judge_byte(input logic [7:0] b, output bit ends,
                             output frame_verdict_type v);
      int p;
      p = int'(pkt_pos);
      ends = 1'b0;
      v.status = spc_pkg::ST_OK;
      v.count = '0;
      if (p >= 3 && b == spc_pkg::TERM_BYTE) begin
         ends = 1'b1;
         if (pkt_err != spc_pkg::ST_OK) begin
            v.status = pkt_err;
         end else if (p == 3) begin
            v.status = spc_pkg::ST_LEN_MISMATCH;
         end else if (pkt_sum != pkt_prev) begin
            v.status = spc_pkg::ST_CKSUM;
         end else if (p - 4 != int'(pkt_decl)) begin
            v.status = spc_pkg::ST_LEN_MISMATCH;
         end
         // The counted length saturates, but the comparison above used all of it.
         if (p >= 4) begin
            v.count = (p - 4 > 255) ? 8'd255 : 8'(p - 4);
         end
         clear_packet();
      end else begin
         case (p)
            0: begin
               if (b != spc_pkg::HDR0_BYTE && pkt_err == spc_pkg::ST_OK) begin
                  pkt_err = spc_pkg::ST_BAD_HEADER;
               end
            end
            1: begin
               if (b != spc_pkg::HDR1_BYTE && pkt_err == spc_pkg::ST_OK) begin
                  pkt_err = spc_pkg::ST_BAD_HEADER;
               end
            end
            2: begin
               pkt_decl = b;
               if (b == 8'h00 && pkt_err == spc_pkg::ST_OK) pkt_err = spc_pkg::ST_ZERO_LEN;
            end
            3: ;
            default: pkt_sum = pkt_sum + pkt_prev;
         endcase
         // Too long without a terminator: a header or length error still wins.
         if (p + 1 >= int'(limit_len)) begin
            ends = 1'b1;
            v.status = (pkt_err != spc_pkg::ST_OK) ? pkt_err : spc_pkg::ST_OVERRUN;
            clear_packet();
         end else begin
            pkt_prev = b;
            pkt_pos = spc_pkg::POS_W'(p + 1);
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Checks results, predicts accepted items and watches for a stuck run.
   always @(posedge clock) begin : watch
      frame_verdict_type want;
      frame_verdict_type got;
      bit ends;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result: status %0d count %0d",
                                         rsp_status, rsp_payload_count));
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_status != want.status || rsp_payload_count != want.count) begin
                  report_mismatch($sformatf(
                     "mismatch: expected status %0d count %0d, got status %0d count %0d",
                     want.status, want.count, rsp_status, rsp_payload_count));
               end
            end
         end
         if (req_valid && !req_stall) begin
            judge_byte(req_data_byte, ends, got);
            if (req_typed) begin
               want.status = req_typed_status;
               want.count = req_typed_count;
               verdicts_due.push_back(want);
            end else if (ends) begin
               verdicts_due.push_back(got);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: stall pattern that changes character from one random segment to the next,
   // with one long hold-off as soon as it is asked for.
   initial begin : receiver
      int seg;
      int mode;
      forever begin
         if (hold_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_wanted = 1'b0;
         end else begin
            seg = $urandom_range(8, 60);
            mode = $urandom_range(0, 2);
            repeat (seg) begin
               if (!hold_wanted) begin
                  case (mode)
                     0: rsp_stall <= 1'b0;
                     1: rsp_stall <= ($urandom_range(0, 3) == 0);
                     default: rsp_stall <= ($urandom_range(0, 3) != 0);
                  endcase
                  @(posedge clock);
               end
            end
         end
      end
   end

   // Offers one item and returns at the edge where it is accepted. The sender
   // works in bursts, with a gap before most of them.
   task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input spc_pkg::status_type st = spc_pkg::ST_OK,
                            input logic [7:0] cnt = 8'd0);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_typed <= typed;
      req_typed_status <= st;
      req_typed_count <= cnt;
      bytes_offered++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering and waits until every result has come and the pipeline is empty.
   // The first edge lets the predictor take in the last accepted item.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic logic [7:0] any_but_term();
      logic [7:0] b;
      b = 8'($urandom_range(0, 254));
      if (b >= spc_pkg::TERM_BYTE) b++;
      return b;
   endfunction

   // Builds one packet of the given kind with random content and sends it.
   task automatic send_packet(input frame_kind_type kind);
      logic [7:0] frame[$];
      logic [7:0] pay[$];
      logic [7:0] b;
      logic [7:0] ck;
      logic [7:0] decl;
      int lmax;
      int n;
      lmax = int'(limit_len) - 5;
      if (lmax > 255) lmax = 255;
      if (kind != PK_NOISE && kind != PK_OVERRUN && kind != PK_LONG && lmax < 1) begin
         kind = PK_OVERRUN;
      end
      case (kind)
         PK_NOISE: begin
            repeat ($urandom_range(1, 10)) begin
               frame.push_back(($urandom_range(0, 3) == 0) ? spc_pkg::TERM_BYTE
                                                           : 8'($urandom));
            end
         end
         PK_OVERRUN: begin
            frame.push_back(spc_pkg::HDR0_BYTE);
            frame.push_back(spc_pkg::HDR1_BYTE);
            frame.push_back(8'($urandom_range(1, 255)));
            while (frame.size() < int'(limit_len)) frame.push_back(any_but_term());
         end
         default: begin
            if (kind == PK_LONG) begin
               n = 256;
            end else if (lmax <= 24 && $urandom_range(0, 7) == 0) begin
               // Terminator on the last byte the limit allows.
               n = lmax;
            end else begin
               n = $urandom_range(1, (lmax < 12) ? lmax : 12);
            end
            // A checksum equal to the terminator would end the packet early.
            do begin
               pay.delete();
               ck = '0;
               repeat (n) begin
                  b = any_but_term();
                  pay.push_back(b);
                  ck = ck + b;
               end
            end while (ck == spc_pkg::TERM_BYTE);
            decl = (kind == PK_LONG) ? 8'd255 : 8'(n);
            if (kind == PK_LEN_OFF) decl = decl + 8'($urandom_range(1, 255));
            if (kind == PK_ZERO_LEN) decl = 8'h00;
            if (kind == PK_BAD_SUM) ck = ck ^ (8'd1 << $urandom_range(0, 7));
            frame.push_back(spc_pkg::HDR0_BYTE);
            frame.push_back(spc_pkg::HDR1_BYTE);
            frame.push_back(decl);
            foreach (pay[i]) frame.push_back(pay[i]);
            frame.push_back(ck);
            frame.push_back(spc_pkg::TERM_BYTE);
            if (kind == PK_BAD_HDR) begin
               if ($urandom_range(0, 1) == 0) frame[0] = 8'($urandom_range(0, 254));
               else frame[1] = 8'($urandom_range(1, 255));
            end
         end
      endcase
      foreach (frame[i]) send_byte(frame[i]);
   endtask

   function automatic frame_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return PK_GOOD;
      if (r < 68) return PK_LEN_OFF;
      if (r < 76) return PK_BAD_SUM;
      if (r < 82) return PK_BAD_HDR;
      if (r < 86) return PK_ZERO_LEN;
      if (r < 92) return (limit_len <= 64) ? PK_OVERRUN : PK_GOOD;
      return PK_NOISE;
   endfunction

   // One phase of random packets under one length limit. It ends part-way into
   // a packet, so the next limit can land on a packet already under way.
   task automatic run_phase(input logic [spc_pkg::LEN_W-1:0] limit, input bit write_it,
                            input int budget, input bit with_long);
      int start;
      if (write_it) begin
         csr_wr_en <= 1'b1;
         csr_wr_data <= limit;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         limit_len = limit;
      end
      if (with_long) send_packet(PK_LONG);
      start = bytes_offered;
      while (bytes_offered - start < budget) send_packet(pick_kind());
      send_byte(spc_pkg::HDR0_BYTE);
      send_byte(spc_pkg::HDR1_BYTE);
      send_byte(8'($urandom_range(1, 255)));
      repeat ($urandom_range(0, 10)) send_byte(any_but_term());
      drain();
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_typed <= 1'b0;
      req_typed_status <= spc_pkg::ST_OK;
      req_typed_count <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      limit_len = spc_pkg::MAX_LEN_RESET;
      clear_packet();
      fail_count = 0;
      stuck_cycles = 0;
      burst_left = 0;
      bytes_offered = 0;
      hold_wanted = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) begin
         send_byte(opening_bytes[i].data, opening_bytes[i].typed,
                   opening_bytes[i].status, opening_bytes[i].count);
      end
      drain();

      // Reset limit first, then the short limit with the long hold-off so the
      // block backs up, then limits too short for any payload, the widest limit
      // with a payload count that saturates, and back to ordinary ones.
      run_phase(spc_pkg::MAX_LEN_RESET, 1'b0, 12, 1'b0);
      hold_wanted = 1'b1;
      run_phase(9'd6, 1'b1, 24, 1'b0);
      run_phase(9'd0, 1'b1, 4, 1'b0);
      run_phase(9'd1, 1'b1, 4, 1'b0);
      run_phase(9'd3, 1'b1, 6, 1'b0);
      run_phase(9'd511, 1'b1, 8, 1'b1);
      run_phase(9'd20, 1'b1, 12, 1'b0);
      run_phase(9'd260, 1'b1, 12, 1'b0);

      if (fail_count == 0 && verdicts_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
